// ===== sv/prq_pkg.sv =====
// shared types and constants for the priority ready queue dispatcher
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 32;

    localparam int JOB_ID_W   = 16;
    localparam int PRIO_W     = 8;
    localparam int BURST_W    = 16;
    localparam int LEFT_W     = BURST_W + 1;
    localparam int COUNT_W    = 6;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DISP   = 2'd1,
        EV_TERM   = 2'd2,
        EV_REJECT = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARR,
        ST_SCAN,
        ST_INS,
        ST_DISP,
        ST_REPLY
    } t_state;

    // one waiting job as stored in the queue memory
    typedef struct packed {
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
        logic [JOB_ID_W-1:0] id;
    } t_entry;

    typedef struct packed {
        t_event              code;
        logic [JOB_ID_W-1:0] job;
        logic [COUNT_W-1:0]  count;
        logic                busy;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/prq_ram.sv =====
// ready queue storage: one write port, one read port, registered read data
`timescale 1ns / 1ps
`default_nettype none

module prq_ram
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int ADDR_W = $clog2(QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_entry            i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_entry                 o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/prq_ctrl.sv =====
// queue sequencer: sorted insert walk, dispatch, running slot and tick handling
`timescale 1ns / 1ps
`default_nettype none

module prq_ctrl
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int ADDR_W = $clog2(QUEUE_DEPTH),
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire logic              i_req_type,
    input  wire t_entry            i_job,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res,
    output logic                   o_mem_we,
    output logic [ADDR_W-1:0]      o_mem_waddr,
    output t_entry                 o_mem_wdata,
    output logic [ADDR_W-1:0]      o_mem_raddr,
    input  wire t_entry            i_mem_rdata
);

    localparam logic [ADDR_W:0]   DEPTH_SUM = (ADDR_W + 1)'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] FULL      = FILL_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);

    function automatic logic [ADDR_W-1:0] f_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] f_inc(input logic [ADDR_W-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_busy, n_busy;
    logic [JOB_ID_W-1:0] r_run_job, n_run_job;
    logic [LEFT_W-1:0]   r_run_left, n_run_left;
    t_event              r_code, n_code;
    logic [JOB_ID_W-1:0] r_ev_job, n_ev_job;
    t_entry              r_item, n_item;
    logic [ADDR_W-1:0]   r_wptr, n_wptr;
    logic [ADDR_W-1:0]   r_rptr, n_rptr;
    logic [FILL_W-1:0]   r_cnt, n_cnt;

    logic [ADDR_W:0]     tail_sum;
    logic [ADDR_W-1:0]   tail;

    // slot just past the last waiting job, wrapped around the ring
    always_comb begin
        tail_sum = {1'b0, r_head} + (ADDR_W + 1)'(r_fill);
        if (tail_sum >= DEPTH_SUM) begin
            tail = ADDR_W'(tail_sum - DEPTH_SUM);
        end else begin
            tail = ADDR_W'(tail_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_busy     <= 1'b0;
            r_run_job  <= '0;
            r_run_left <= '0;
            r_code     <= EV_NONE;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_fill     <= n_fill;
            r_busy     <= n_busy;
            r_run_job  <= n_run_job;
            r_run_left <= n_run_left;
            r_code     <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_job <= n_ev_job;
        r_item   <= n_item;
        r_wptr   <= n_wptr;
        r_rptr   <= n_rptr;
        r_cnt    <= n_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_busy      = r_busy;
        n_run_job   = r_run_job;
        n_run_left  = r_run_left;
        n_code      = r_code;
        n_ev_job    = r_ev_job;
        n_item      = r_item;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_cnt       = r_cnt;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wptr;
        o_mem_wdata = r_item;
        o_mem_raddr = r_rptr;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_type == REQ_ARRIVE) begin
                        n_ev_job = i_job.id;
                        if (r_fill == FULL) begin
                            n_code  = EV_REJECT;
                            n_state = ST_REPLY;
                        end else begin
                            n_code  = EV_NONE;
                            n_item  = i_job;
                            n_wptr  = tail;
                            n_rptr  = f_dec(tail);
                            n_cnt   = r_fill;
                            n_state = ST_ARR;
                        end
                    end else if (r_busy) begin
                        n_ev_job = r_run_job;
                        if (r_run_left <= LEFT_W'(1)) begin
                            n_run_left = '0;
                            n_busy     = 1'b0;
                            n_code     = EV_TERM;
                        end else begin
                            n_run_left = r_run_left - 1'b1;
                            n_code     = EV_NONE;
                        end
                        n_state = ST_REPLY;
                    end else if (r_fill == '0) begin
                        n_ev_job = '0;
                        n_code   = EV_NONE;
                        n_state  = ST_REPLY;
                    end else begin
                        o_mem_raddr = r_head;
                        n_state     = ST_DISP;
                    end
                end
            end

            ST_ARR: begin
                if (r_cnt == '0) begin
                    n_state = ST_INS;
                end else begin
                    n_rptr  = f_dec(r_rptr);
                    n_cnt   = r_cnt - 1'b1;
                    n_state = ST_SCAN;
                end
            end

            // compare the entry read last cycle; shift it up while the next read is issued
            ST_SCAN: begin
                o_mem_we = 1'b1;
                if (i_mem_rdata.prio < r_item.prio) begin
                    o_mem_wdata = i_mem_rdata;
                    n_wptr      = f_dec(r_wptr);
                    if (r_cnt == '0) begin
                        n_state = ST_INS;
                    end else begin
                        n_rptr = f_dec(r_rptr);
                        n_cnt  = r_cnt - 1'b1;
                    end
                end else begin
                    n_fill  = r_fill + 1'b1;
                    n_state = ST_REPLY;
                end
            end

            ST_INS: begin
                o_mem_we = 1'b1;
                n_fill   = r_fill + 1'b1;
                n_state  = ST_REPLY;
            end

            ST_DISP: begin
                n_run_job  = i_mem_rdata.id;
                n_run_left = {1'b0, i_mem_rdata.burst};
                n_busy     = 1'b1;
                n_head     = f_inc(r_head);
                n_fill     = r_fill - 1'b1;
                n_code     = EV_DISP;
                n_ev_job   = i_mem_rdata.id;
                n_state    = ST_REPLY;
            end

            ST_REPLY: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.code  = r_code;
        o_res.job   = r_ev_job;
        o_res.count = COUNT_W'(r_fill);
        o_res.busy  = r_busy;
    end

endmodule

`default_nettype wire

// ===== sv/priority_ready_queue_dispatcher.sv =====
// top level: stream ports, result register, queue sequencer and queue memory
`timescale 1ns / 1ps
`default_nettype none

// Non-preemptive priority dispatcher. Arrivals (tuser = 0) are inserted into a
// priority-sorted ready queue held in a ring in one single-port-read memory;
// the insert walks backwards from the tail, moving one lower-priority entry per
// cycle, past every waiting job of strictly lower priority. A dispatch tick is
// bound by the registered read data of the memory. One item is in work at a
// time; the result register lets the next item be taken while the previous
// result waits. The memory is not cleared after reset, the block is ready at
// once.
module priority_ready_queue_dispatcher
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // job_id [15:0], job_priority [23:16], burst_ticks [39:24]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // event_job [15:0], ready_count [21:16], cpu_busy [22], zero [23]
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // event_code
    output logic [1:0]                m_axis_tuser
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);

    t_entry            in_job;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    t_entry            mem_rdata;

    logic              r_out_valid;
    t_result           r_out;

    always_comb begin
        in_job.id    = s_axis_tdata[15:0];
        in_job.prio  = s_axis_tdata[23:16];
        in_job.burst = s_axis_tdata[39:24];
    end

    prq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .i_job       (in_job),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    prq_ram #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.code;
    assign m_axis_tdata  = {1'b0, r_out.busy, r_out.count, r_out.job};

    // a pending result from the sequencer is never dropped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("sequencer result dropped while stalled");

    // a dispatch leaves the processor busy, a termination leaves it idle
    a_busy_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && (res.code == EV_DISP || res.code == EV_TERM)
            |-> res.busy == (res.code == EV_DISP))
        else $error("cpu_busy does not match event code");

    // a rejection only happens on a full queue
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.code == EV_REJECT |-> res.count == COUNT_W'(QUEUE_DEPTH))
        else $error("rejection reported with queue not full");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the priority ready queue dispatcher
module tb;
    import prq_pkg::*;

    localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 50;
    localparam int RANDOM_ITEMS = 1250;
    localparam int REPORT_MAX   = 10;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    // shadow of the dispatcher: sorted ready queue and the running slot
    t_entry              ready_q[$];
    logic [JOB_ID_W-1:0] cpu_job  = '0;
    logic [LEFT_W-1:0]   cpu_left = '0;
    logic                cpu_busy = 1'b0;

    t_result expected_events[$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      hold_cycles = 0;
    bit      tx_gaps     = 1'b0;
    bit      rx_gaps     = 1'b0;

    priority_ready_queue_dispatcher #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // advance the shadow by one accepted transaction and queue the event it must produce
    task automatic predict_event(input logic req, input t_entry job);
        t_result ev;
        int      pos;
        ev.code = EV_NONE;
        ev.job  = '0;
        pos     = ready_q.size();
        if (req == REQ_ARRIVE) begin
            ev.job = job.id;
            if (ready_q.size() >= DEPTH) begin
                ev.code = EV_REJECT;
            end else begin
                // goes ahead of the first strictly lower priority, behind equal ones
                foreach (ready_q[i]) begin
                    if (pos == ready_q.size() && ready_q[i].prio < job.prio) begin
                        pos = i;
                    end
                end
                ready_q.insert(pos, job);
            end
        end else if (!cpu_busy) begin
            if (ready_q.size() != 0) begin
                cpu_job  = ready_q[0].id;
                cpu_left = {1'b0, ready_q[0].burst};
                ready_q.delete(0);
                cpu_busy = 1'b1;
                ev.code  = EV_DISP;
                ev.job   = cpu_job;
            end
        end else begin
            ev.job = cpu_job;
            // a zero burst ends on the first busy tick like a burst of one
            if (cpu_left <= 1) begin
                cpu_left = '0;
                cpu_busy = 1'b0;
                ev.code  = EV_TERM;
            end else begin
                cpu_left = cpu_left - 1'b1;
            end
        end
        ev.count = COUNT_W'(ready_q.size());
        ev.busy  = cpu_busy;
        expected_events.push_back(ev);
    endtask

    task automatic send_item(input logic req, input t_entry job);
        if (tx_gaps && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= job;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_event(req, job);
    endtask

    task automatic send_arrival(input logic [15:0] id, input logic [7:0] prio,
                                input logic [15:0] burst);
        t_entry job;
        job.id    = id;
        job.prio  = prio;
        job.burst = burst;
        send_item(REQ_ARRIVE, job);
    endtask

    // the job fields of a tick are don't-care, so fill them with noise
    task automatic send_tick();
        t_entry junk;
        junk.id    = 16'($urandom);
        junk.prio  = 8'($urandom);
        junk.burst = 16'($urandom);
        send_item(REQ_TICK, junk);
    endtask

    task automatic send_random(input int arrive_pct);
        t_entry job;
        int     pick;
        job.id = 16'($urandom);
        case ($urandom_range(0, 3))
            0, 1: job.prio = 8'($urandom_range(0, 3));
            2: job.prio = 8'($urandom);
            default: job.prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            job.burst = 16'($urandom_range(0, 2));
        end else if (pick < 97) begin
            job.burst = 16'($urandom_range(3, 12));
        end else begin
            job.burst = 16'($urandom_range(13, 100));
        end
        // a full queue drops the job, so any burst is safe here
        if (ready_q.size() >= DEPTH) begin
            job.burst = 16'($urandom);
        end
        if ($urandom_range(0, 99) < arrive_pct) begin
            send_item(REQ_ARRIVE, job);
        end else begin
            send_tick();
        end
    endtask

    task automatic wait_reported();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
    endtask

    task automatic run_until_idle();
        while (ready_q.size() != 0 || cpu_busy) begin
            send_tick();
        end
    endtask

    task automatic test_empty_tick();
        send_tick();
        send_tick();
    endtask

    task automatic test_ordering();
        send_arrival(16'h0000, 8'h00, 16'h0000);
        send_arrival(16'hFFFF, 8'hFF, 16'h0001);
        send_arrival(16'h1111, 8'h80, 16'h0002);
        send_arrival(16'h2222, 8'h80, 16'h0000);
        send_arrival(16'h3333, 8'h80, 16'h0003);
        send_arrival(16'hAAAA, 8'h55, 16'h0001);
        send_arrival(16'h5555, 8'hAA, 16'h0002);
        send_tick();
        // arrives while busy and must land at the head
        send_arrival(16'h8001, 8'hFF, 16'h0000);
        send_tick();
        send_arrival(16'h0102, 8'h00, 16'h0001);
        run_until_idle();
    endtask

    task automatic test_queue_full();
        while (ready_q.size() < DEPTH) begin
            send_arrival(16'($urandom), 8'($urandom_range(0, 7)), 16'($urandom_range(0, 3)));
        end
        send_arrival(16'hFFFF, 8'hFF, 16'hFFFF);
        send_arrival(16'h0000, 8'h00, 16'h0000);
        send_arrival(16'($urandom), 8'($urandom), 16'($urandom));
        send_tick();
        send_arrival(16'h7E57, 8'hFF, 16'h0001);
        send_arrival(16'h7E58, 8'hFF, 16'h0001);
        run_until_idle();
    endtask

    task automatic test_backpressure();
        wait_reported();
        hold_cycles = HOLD_CYCLES;
        repeat (12) begin
            send_random(60);
        end
        wait_reported();
    endtask

    task automatic test_long_burst();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_until_idle();
        send_arrival(16'hC3C3, 8'hFF, 16'h0064);
        run_until_idle();
    endtask

    task automatic test_random();
        int sent;
        int seg_len;
        int arrive_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(20, 80);
            // mix filling and draining phases at random so the queue swings between empty and full
            case ($urandom_range(0, 2))
                0: arrive_pct = 70;
                1: arrive_pct = 35;
                default: arrive_pct = 10;
            endcase
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            repeat (seg_len) begin
                send_random(arrive_pct);
                sent++;
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_until_idle();
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.code  = t_event'(m_axis_tuser);
            seen.job   = m_axis_tdata[JOB_ID_W-1:0];
            seen.count = m_axis_tdata[JOB_ID_W +: COUNT_W];
            seen.busy  = m_axis_tdata[JOB_ID_W + COUNT_W];
            if (expected_events.size() == 0) begin
                note_mismatch($sformatf("unexpected transaction code %0d job %h",
                                        seen.code, seen.job));
            end else begin
                want = expected_events.pop_front();
                if (seen.code != want.code || seen.job != want.job ||
                        seen.count != want.count || seen.busy != want.busy) begin
                    note_mismatch($sformatf(
                        "expected code %0d job %h count %0d busy %0d, got code %0d job %h count %0d busy %0d",
                        want.code, want.job, want.count, want.busy,
                        seen.code, seen.job, seen.count, seen.busy));
                end
            end
        end
    end

    initial begin : result_sink
        int gap_left;
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 99) < 25) begin
                gap_left = pick_gap() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_empty_tick();
        test_ordering();
        test_queue_full();
        test_backpressure();
        test_long_burst();
        test_random();
        wait_reported();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/prq_pkg.sv
sv/prq_ram.sv
sv/prq_ctrl.sv
sv/priority_ready_queue_dispatcher.sv
tb/sv/tb.sv
